### rtl/core/assert_macros.svh
// Assertion helper macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property under clock and synchronous reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Assert a property that must also hold during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/sack_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sack_pkg
// Shared types, constants and helpers of the selective acknowledgment
// receiver scoreboard.
// ----------------------------------------------------------------------------
package sack_pkg;

   localparam int unsigned BoardEntries   = 64;
   localparam int unsigned ReportedBlocks = 5;
   localparam logic [30:0] WindowReset    = 31'd819200;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN_RD,
      ST_SCAN,
      ST_WRFRONT,
      ST_POP_RD,
      ST_POP,
      ST_EMIT_RD,
      ST_EMIT
   } state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load_req;
      logic restart;
      logic count_rx;
      logic count_dup;
      logic scan_start;
      logic scan_step;
      logic write_front;
      logic pop_start;
      logic pop_step;
      logic pop_finish;
      logic emit_start;
      logic emit_step;
      logic ack_done;
      logic set_deferred;
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic new_track;
      logic out_window;
      logic stale;
      logic in_order;
      logic scan_last;
      logic pop_none;
      logic pop_last;
      logic emit_last;
      logic deferred;
   } status_type;

   function automatic logic seq_before(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] d;
      begin
         d = a - b;
         return d[31];
      end
   endfunction

endpackage

### rtl/core/sack_receiver_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sack_receiver_scoreboard
// Selective acknowledgment receiver: window check, scoreboard merge, report.
// ----------------------------------------------------------------------------
// A new track, out-of-window or stale request goes straight to the report; else the
//   board is scanned and merged, in-order blocks are popped, and a report may follow.
// A new request is taken only in idle, once the previous one is done; response
//   back-pressure stalls the report.
// Reset: synchronous, clears all counters and empties the board; window 819200.
module sack_receiver_scoreboard #(
   parameter int unsigned BOARD_ENTRIES   = sack_pkg::BoardEntries,
   parameter int unsigned REPORTED_BLOCKS = sack_pkg::ReportedBlocks
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [30:0]  csr_wr_data,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // track_id, seq_num, ts_value
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [263:0] rsp_tdata,   // ack_serial, ack_next, ack_stamp, ts_echo,
                                     // received_total, duplicate_total,
                                     // block_count, block_start, block_end
   output logic         rsp_tuser,   // board_overflow
   output logic         rsp_tlast    // last_of_ack
);

   logic [30:0] window_ff;
   sack_pkg::cmd_type    cmd;
   sack_pkg::status_type status;
   logic [263:0] data;
   logic [1:0]   flags;
   logic         load, fire, valid_ff;
   logic [263:0] tdata_ff;
   logic [1:0]   flags_ff;

   always_ff @(posedge clock) begin
      if (reset) window_ff <= sack_pkg::WindowReset;
      else if (csr_wr_en) window_ff <= csr_wr_data;
   end

   assign fire = valid_ff && rsp_tready;

   sack_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_fire(fire), .rsp_busy(valid_ff && !rsp_tready), .status(status),
      .cmd(cmd), .rsp_load(load));

   sack_dpath #(.BOARD_ENTRIES(BOARD_ENTRIES), .REPORTED_BLOCKS(REPORTED_BLOCKS)) u_dp (
      .clock(clock), .reset(reset), .window(window_ff), .req_tdata(req_tdata),
      .cmd(cmd), .status(status), .rsp_data(data), .rsp_flags(flags));

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (load) valid_ff <= 1'b1;
      else if (fire) valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         tdata_ff <= data;
         flags_ff <= flags;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = tdata_ff;
   assign rsp_tuser = flags_ff[1];
   assign rsp_tlast = flags_ff[0];

endmodule

### rtl/core/sack_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sack_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module sack_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/sack_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sack_ctrl
// Packet sequencer: classify, scan and merge, pop front, emit report.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sack_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  rsp_fire,
   input  logic                  rsp_busy,
   input  sack_pkg::status_type  status,
   output sack_pkg::cmd_type     cmd,
   output logic                  rsp_load
);

   sack_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sack_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sack_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = sack_pkg::ST_CHECK;
         end
         sack_pkg::ST_CHECK: begin
            if (status.new_track || status.out_window || status.stale) begin
               state_in = sack_pkg::ST_EMIT_RD;
            end else begin
               state_in = sack_pkg::ST_SCAN_RD;
            end
         end
         sack_pkg::ST_SCAN_RD: state_in = sack_pkg::ST_SCAN;
         sack_pkg::ST_SCAN: begin
            if (status.scan_last) state_in = sack_pkg::ST_WRFRONT;
            else state_in = sack_pkg::ST_SCAN_RD;
         end
         sack_pkg::ST_WRFRONT: begin
            if (!status.in_order) state_in = sack_pkg::ST_EMIT_RD;
            else if (status.pop_none) begin
               if (status.deferred) state_in = sack_pkg::ST_EMIT_RD;
               else state_in = sack_pkg::ST_IDLE;
            end else state_in = sack_pkg::ST_POP_RD;
         end
         sack_pkg::ST_POP_RD: state_in = sack_pkg::ST_POP;
         sack_pkg::ST_POP: begin
            if (status.pop_last) begin
               if (status.deferred) state_in = sack_pkg::ST_EMIT_RD;
               else state_in = sack_pkg::ST_IDLE;
            end else state_in = sack_pkg::ST_POP_RD;
         end
         sack_pkg::ST_EMIT_RD: begin
            if (!rsp_busy) state_in = sack_pkg::ST_EMIT;
         end
         sack_pkg::ST_EMIT: begin
            if (status.emit_last) state_in = sack_pkg::ST_IDLE;
            else state_in = sack_pkg::ST_EMIT_RD;
         end
         default: state_in = sack_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      rsp_load = 1'b0;
      case (state_ff)
         sack_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load_req = req_tvalid;
         end
         sack_pkg::ST_CHECK: begin
            cmd.restart = status.new_track;
            cmd.count_rx = !status.new_track && !status.out_window;
            cmd.count_dup = !status.new_track && !status.out_window && status.stale;
            cmd.scan_start = !(status.new_track || status.out_window || status.stale);
            cmd.emit_start = status.new_track || status.out_window || status.stale;
         end
         sack_pkg::ST_SCAN: cmd.scan_step = 1'b1;
         sack_pkg::ST_WRFRONT: begin
            cmd.write_front = 1'b1;
            cmd.pop_start = status.in_order;
            cmd.emit_start = !status.in_order;
         end
         sack_pkg::ST_POP: cmd.pop_step = 1'b1;
         sack_pkg::ST_EMIT_RD: ;
         sack_pkg::ST_EMIT: begin
            cmd.emit_step = 1'b1;
            rsp_load = 1'b1;
            cmd.ack_done = status.emit_last;
         end
         default: ;
      endcase
      if ((state_ff == sack_pkg::ST_WRFRONT && status.in_order && status.pop_none) ||
          (state_ff == sack_pkg::ST_POP && status.pop_last)) begin
         cmd.pop_finish = 1'b1;
         cmd.set_deferred = !status.deferred;
         cmd.emit_start = status.deferred;
      end
   end

   `ASSERT_CLK(a_ready_idle, clock, reset,
      req_tready |-> state_ff == sack_pkg::ST_IDLE, "ready outside idle")
   `ASSERT_CLK(a_load_free, clock, reset,
      rsp_load |-> !rsp_busy || rsp_fire, "response overwritten")
   `ASSERT_CLK(a_one_cmd, clock, reset,
      $countones({cmd.scan_step, cmd.pop_step, cmd.emit_step}) <= 1, "overlapping steps")

endmodule

### rtl/core/sack_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sack_dpath
// Receiver state, board memories, scan and merge, pop and report.
// ----------------------------------------------------------------------------
module sack_dpath #(
   parameter int unsigned BOARD_ENTRIES   = sack_pkg::BoardEntries,
   parameter int unsigned REPORTED_BLOCKS = sack_pkg::ReportedBlocks
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [30:0]          window,
   input  logic [95:0]          req_tdata,
   input  sack_pkg::cmd_type    cmd,
   output sack_pkg::status_type status,
   output logic [263:0]         rsp_data,
   output logic [1:0]           rsp_flags
);

   localparam int unsigned AW = $clog2(BOARD_ENTRIES);
   localparam int unsigned CW = $clog2(BOARD_ENTRIES + 1);
   localparam int unsigned RW = $clog2(REPORTED_BLOCKS + 1);

   logic [31:0] trk_ff, seq_ff, ts_ff;
   logic        seen_ff, deferred_ff;
   logic [31:0] cur_track_ff, next_ff, stamp_ff, rx_ff, dup_ff, serial_ff, ackts_ff;
   logic [CW-1:0] used_ff;
   // a separate ping-pong bank pair avoids in-place overwrites during compaction
   logic        bank_ff;
   logic [CW-1:0] idx_ff, wr_ff;
   logic [31:0] ns_ff, ne_ff;
   logic        cov_ff, drop_ff;
   logic [RW-1:0] nrep_ff;

   logic [AW-1:0] rd_addr, wr_addr;
   logic          wr_en_a, wr_en_b;
   logic [31:0]   ws, we;
   logic [31:0]   rs_a, re_a, rs_b, re_b, rs, re;
   logic [CW-1:0] rep_src;

   sack_ram #(.WIDTH(32), .DEPTH(BOARD_ENTRIES)) u_sa (
      .clock(clock), .wr_en(wr_en_a), .wr_addr(wr_addr), .wr_data(ws),
      .rd_addr(rd_addr), .rd_data(rs_a));
   sack_ram #(.WIDTH(32), .DEPTH(BOARD_ENTRIES)) u_ea (
      .clock(clock), .wr_en(wr_en_a), .wr_addr(wr_addr), .wr_data(we),
      .rd_addr(rd_addr), .rd_data(re_a));
   sack_ram #(.WIDTH(32), .DEPTH(BOARD_ENTRIES)) u_sb (
      .clock(clock), .wr_en(wr_en_b), .wr_addr(wr_addr), .wr_data(ws),
      .rd_addr(rd_addr), .rd_data(rs_b));
   sack_ram #(.WIDTH(32), .DEPTH(BOARD_ENTRIES)) u_eb (
      .clock(clock), .wr_en(wr_en_b), .wr_addr(wr_addr), .wr_data(we),
      .rd_addr(rd_addr), .rd_data(re_b));

   assign rs = bank_ff ? rs_b : rs_a;
   assign re = bank_ff ? re_b : re_a;

   logic disjoint, covers, keep_write, wr_any, wr_other;
   logic [31:0] lim;

   assign disjoint = sack_pkg::seq_before(ne_ff, rs) || sack_pkg::seq_before(re, ns_ff);
   assign covers = sack_pkg::seq_before(seq_ff, re) && !sack_pkg::seq_before(seq_ff, rs);
   assign keep_write = cmd.scan_step && (idx_ff < used_ff) && disjoint &&
                       (wr_ff < CW'(BOARD_ENTRIES));
   assign lim = next_ff + {1'b0, window};

   // Scan reads bank, writes other bank from slot 1; front goes to slot 0.
   // Pop reads slot i+1 and writes slot i within the new bank.
   always_comb begin
      wr_any = 1'b0;
      wr_other = 1'b1;
      wr_addr = '0;
      ws = rs;
      we = re;
      rd_addr = idx_ff[AW-1:0];
      if (keep_write) begin
         wr_any = 1'b1;
         wr_addr = wr_ff[AW-1:0];
      end else if (cmd.write_front) begin
         wr_any = 1'b1;
         wr_addr = '0;
         ws = ns_ff;
         we = ne_ff;
      end else if (cmd.pop_step) begin
         wr_any = 1'b1;
         wr_other = 1'b0;
         wr_addr = AW'(idx_ff - CW'(1));
      end
      wr_en_a = wr_any && (wr_other ? bank_ff : !bank_ff);
      wr_en_b = wr_any && (wr_other ? !bank_ff : bank_ff);
   end

   // Block count of the report: the board as it stands after this cycle.
   always_comb begin
      rep_src = used_ff;
      if (cmd.restart) rep_src = '0;
      else if (cmd.write_front) rep_src = status.in_order ? wr_ff - CW'(1) : wr_ff;
   end

   assign status.new_track = !seen_ff || (trk_ff != cur_track_ff);
   assign status.out_window = sack_pkg::seq_before(lim, seq_ff);
   assign status.stale = sack_pkg::seq_before(seq_ff, next_ff);
   assign status.in_order = (seq_ff == next_ff);
   assign status.scan_last = (idx_ff + CW'(1) >= used_ff);
   assign status.pop_none = (wr_ff <= CW'(1));
   assign status.pop_last = (idx_ff >= used_ff);
   assign status.emit_last = (idx_ff + CW'(1) >= CW'(nrep_ff)) || (nrep_ff == '0);
   assign status.deferred = deferred_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         trk_ff <= req_tdata[31:0];
         seq_ff <= req_tdata[63:32];
         ts_ff  <= req_tdata[95:64];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
         deferred_ff <= 1'b0;
         cur_track_ff <= '0;
         next_ff <= '0;
         stamp_ff <= '0;
         rx_ff <= '0;
         dup_ff <= '0;
         serial_ff <= '0;
         ackts_ff <= '0;
         used_ff <= '0;
         bank_ff <= 1'b0;
         idx_ff <= '0;
         wr_ff <= '0;
         ns_ff <= '0;
         ne_ff <= '0;
         cov_ff <= 1'b0;
         drop_ff <= 1'b0;
         nrep_ff <= '0;
      end else begin
         if (cmd.load_req) drop_ff <= 1'b0;
         if (cmd.restart) begin
            seen_ff <= 1'b1;
            cur_track_ff <= trk_ff;
            used_ff <= '0;
            next_ff <= seq_ff + 32'd1;
            stamp_ff <= ts_ff;
            rx_ff <= 32'd1;
            dup_ff <= '0;
            drop_ff <= 1'b0;
         end
         if (cmd.count_rx) begin
            rx_ff <= rx_ff + 32'd1;
            if (sack_pkg::seq_before(stamp_ff, ts_ff)) stamp_ff <= ts_ff;
            drop_ff <= 1'b0;
         end
         if (cmd.count_dup) dup_ff <= dup_ff + 32'd1;
         if (cmd.scan_start) begin
            idx_ff <= '0;
            wr_ff <= CW'(1);
            ns_ff <= seq_ff;
            ne_ff <= seq_ff + 32'd1;
            cov_ff <= 1'b0;
         end
         if (cmd.scan_step) begin
            if (idx_ff < used_ff) begin
               if (disjoint) begin
                  if (wr_ff < CW'(BOARD_ENTRIES)) wr_ff <= wr_ff + CW'(1);
                  else drop_ff <= 1'b1;
               end else begin
                  if (covers) cov_ff <= 1'b1;
                  if (sack_pkg::seq_before(rs, ns_ff)) ns_ff <= rs;
                  if (sack_pkg::seq_before(ne_ff, re)) ne_ff <= re;
               end
            end
            idx_ff <= idx_ff + CW'(1);
         end
         if (cmd.write_front) begin
            bank_ff <= !bank_ff;
            used_ff <= wr_ff;
            if (!status.in_order && cov_ff) dup_ff <= dup_ff + 32'd1;
            if (status.in_order) begin
               next_ff <= ne_ff;
               used_ff <= wr_ff - CW'(1);
            end
         end
         if (cmd.pop_start) idx_ff <= CW'(1);
         if (cmd.pop_step) idx_ff <= idx_ff + CW'(1);
         if (cmd.set_deferred) deferred_ff <= 1'b1;
         if (cmd.emit_start) begin
            idx_ff <= '0;
            nrep_ff <= (rep_src < CW'(REPORTED_BLOCKS)) ? RW'(rep_src) : RW'(REPORTED_BLOCKS);
         end
         if (cmd.emit_step) idx_ff <= idx_ff + CW'(1);
         if (cmd.ack_done) begin
            serial_ff <= serial_ff + 32'd1;
            ackts_ff <= ackts_ff + 32'd1;
            deferred_ff <= 1'b0;
         end
      end
   end

   // Pop reads from slot idx (old slot idx+1 shifted: slot0 was front).
   assign rsp_data = {
      5'd0,
      (nrep_ff == '0) ? 32'd0 : re,
      (nrep_ff == '0) ? 32'd0 : rs,
      3'(nrep_ff),
      dup_ff, rx_ff, stamp_ff, ackts_ff, next_ff, serial_ff};
   assign rsp_flags = {drop_ff, status.emit_last};

endmodule
